FILE: hdl/bcc_pkg.sv
// Shared types, widths and codes of the banded confusion counter.
package bcc_pkg;

  localparam int VAL_W       = 16;  // Q1.15 sample width
  localparam int RATE_W      = 17;  // Q1.16 band step, 65536 = 1.0
  localparam int NB_W        = 5;   // band count register width
  localparam int BAND_W      = 5;   // band index width
  localparam int NUM_MIDDLES = 4;
  localparam int DIM_W       = 2;
  localparam int OC_W        = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_CNT_W   = 32;
  localparam int PROD_W      = 34;  // distance times rate
  localparam int CMP_W       = 40;  // margin compare width, scaled by 2^16

  localparam logic [RATE_W-1:0] RATE_RESET = 17'h10000;
  localparam logic [NB_W-1:0]   NB_RESET   = 5'd1;

  typedef enum logic [OC_W-1:0] {
    OC_TN = 2'd0,
    OC_FN = 2'd1,
    OC_FP = 2'd2,
    OC_TP = 2'd3
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_RATE = 3'd0,
    REG_NUM_BANDS = 3'd1,
    REG_MIDDLE_0  = 3'd2,
    REG_MIDDLE_1  = 3'd3,
    REG_MIDDLE_2  = 3'd4,
    REG_MIDDLE_3  = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CLR_OUT,
    ST_PREP,
    ST_MUL,
    ST_SEARCH,
    ST_READ,
    ST_UPDATE
  } bcc_state_e;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic sweep;     // zero one counter entry and advance
    logic prep;      // classify and set up margin bounds
    logic mul;       // form one band step
    logic search;    // test the next band
    logic rd;        // read the selected counter
    logic upd;       // write back and load the result
    logic zero_out;  // load an all-zero result
  } bcc_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic search_done;
  } bcc_sts_t;

endpackage

FILE: hdl/bcc_if.sv
// Request, response and configuration channel interfaces.
interface bcc_in_if import bcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [DIM_W-1:0]        dim_index;
  logic signed [VAL_W-1:0] expected;
  logic signed [VAL_W-1:0] actual;

  modport source (output valid, mode, dim_index, expected, actual, input ready);
  modport sink   (input valid, mode, dim_index, expected, actual, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OC_W-1:0]      outcome;
  logic [BAND_W-1:0]    band;
  logic [OUT_CNT_W-1:0] cell_count;
  logic [OUT_CNT_W-1:0] total_count;

  modport source (output valid, outcome, band, cell_count, total_count, input ready);
  modport sink   (input valid, outcome, band, cell_count, total_count, output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/bcc_ctrl.sv
// Sequencer of the banded confusion counter.
module bcc_ctrl import bcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bcc_sts_t sts_i,
  output bcc_cmd_t cmd_o
);

  bcc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_fire;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:    if (sts_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE:    if (in_fire) state_d = in_mode_i ? ST_CLEAR : ST_PREP;
      ST_CLEAR:   if (sts_i.sweep_last) state_d = ST_CLR_OUT;
      ST_CLR_OUT: if (out_free) state_d = ST_IDLE;
      ST_PREP:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_SEARCH;
      ST_SEARCH:  if (sts_i.search_done) state_d = ST_READ;
      ST_READ:    state_d = ST_UPDATE;
      ST_UPDATE:  if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_INIT:    cmd_o.sweep = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_fire;
      end
      ST_CLEAR:   cmd_o.sweep = 1'b1;
      ST_CLR_OUT: begin
        cmd_o.zero_out = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      ST_PREP:    cmd_o.prep = 1'b1;
      ST_MUL:     cmd_o.mul = 1'b1;
      ST_SEARCH:  cmd_o.search = 1'b1;
      ST_READ:    cmd_o.rd = 1'b1;
      ST_UPDATE: begin
        cmd_o.upd = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/bcc_dp.sv
// Datapath: configuration registers, band search, counter store and result register.
module bcc_dp import bcc_pkg::*; #(
  parameter int NUM_DIMS    = 4,
  parameter int MAX_BANDS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [DIM_W-1:0]        dim_index_i,
  input  logic signed [VAL_W-1:0] expected_i,
  input  logic signed [VAL_W-1:0] actual_i,
  input  bcc_cmd_t                cmd_i,
  output bcc_sts_t                sts_o,
  output logic [OC_W-1:0]         outcome_o,
  output logic [BAND_W-1:0]       band_o,
  output logic [OUT_CNT_W-1:0]    cell_count_o,
  output logic [OUT_CNT_W-1:0]    total_count_o
);

  localparam int CELL_TOTAL = (MAX_BANDS + 1) * NUM_DIMS * 4;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);

  // configuration
  logic [RATE_W-1:0]       band_rate_q;
  logic [NB_W-1:0]         num_bands_q;
  logic signed [VAL_W-1:0] middle_q [NUM_MIDDLES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_rate_q <= RATE_RESET;
      num_bands_q <= NB_RESET;
      for (int i = 0; i < NUM_MIDDLES; i++) middle_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND_RATE: band_rate_q <= cfg_data_i[RATE_W-1:0];
        REG_NUM_BANDS: num_bands_q <= cfg_data_i[NB_W-1:0];
        REG_MIDDLE_0:  middle_q[0] <= cfg_data_i[VAL_W-1:0];
        REG_MIDDLE_1:  middle_q[1] <= cfg_data_i[VAL_W-1:0];
        REG_MIDDLE_2:  middle_q[2] <= cfg_data_i[VAL_W-1:0];
        REG_MIDDLE_3:  middle_q[3] <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [DIM_W-1:0]        dim_q;
  logic signed [VAL_W-1:0] exp_q, act_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dim_q <= dim_index_i;
      exp_q <= expected_i;
      act_q <= actual_i;
    end
  end

  // classification and margin bounds
  logic signed [VAL_W-1:0]   mid;
  logic                      upper;
  logic signed [VAL_W+1:0]   em, ea;
  logic signed [VAL_W+2:0]   qa;
  logic [RATE_W-1:0]         dist_d, dist_q;
  logic signed [CMP_W-1:0]   p_d, p_q, q_d, q_q;
  logic [OC_W-1:0]           oc_d, oc_q;

  assign mid   = middle_q[dim_q];
  assign upper = exp_q > mid;
  assign em    = (VAL_W+2)'(exp_q) - (VAL_W+2)'(mid);
  assign ea    = (VAL_W+2)'(exp_q) - (VAL_W+2)'(act_q);
  // actual minus twice middle plus expected
  assign qa    = (VAL_W+3)'(act_q) + (VAL_W+3)'(exp_q) - ((VAL_W+3)'(mid) <<< 1);

  always_comb begin
    if (upper) begin
      dist_d = RATE_W'(em);
      p_d    = CMP_W'(ea) <<< 16;
      q_d    = CMP_W'(qa) <<< 16;
      oc_d   = (act_q >= mid) ? OC_TN : OC_FP;
    end else begin
      dist_d = RATE_W'(-em);
      p_d    = (-CMP_W'(ea)) <<< 16;
      q_d    = (-CMP_W'(qa)) <<< 16;
      oc_d   = (act_q <= mid) ? OC_TP : OC_FN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dist_q <= dist_d;
      p_q    <= p_d;
      q_q    <= q_d;
      oc_q   <= oc_d;
    end
  end

  // band step and search
  logic [PROD_W-1:0]       prod;
  logic signed [CMP_W-1:0] step_q, off_q, cand;
  logic [BAND_W-1:0]       cnt_q, limit;
  logic                    go;

  assign prod  = dist_q * band_rate_q;
  assign cand  = off_q + step_q;
  assign limit = (int'(num_bands_q) > MAX_BANDS) ? BAND_W'(MAX_BANDS) : num_bands_q;
  assign go    = (cnt_q < limit) && (cand < p_q) && (cand < q_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) step_q <= CMP_W'(prod);
    if (cmd_i.prep) begin
      cnt_q <= '0;
      off_q <= '0;
    end else if (cmd_i.search && go) begin
      cnt_q <= cnt_q + 1'b1;
      off_q <= cand;
    end
  end

  // counter store
  logic [COUNT_WIDTH-1:0] mem [CELL_TOTAL];
  logic [COUNT_WIDTH-1:0] rd_q, inc, tsel, tinc;
  logic [COUNT_WIDTH-1:0] total_q [4];
  logic [ADDR_W-1:0]      addr, sweep_q, waddr;
  logic                   dim_ok, we;
  logic [COUNT_WIDTH-1:0] wdata;

  assign dim_ok = int'(dim_q) < NUM_DIMS;
  assign addr   = dim_ok ?
                  ADDR_W'((int'(cnt_q) * NUM_DIMS + int'(dim_q)) * 4 + int'(oc_q)) : '0;
  assign inc    = (rd_q == '1) ? rd_q : rd_q + 1'b1;
  assign tsel   = total_q[oc_q];
  assign tinc   = (tsel == '1) ? tsel : tsel + 1'b1;

  assign we    = cmd_i.sweep || (cmd_i.upd && dim_ok);
  assign waddr = cmd_i.sweep ? sweep_q : addr;
  assign wdata = cmd_i.sweep ? '0 : inc;

  assign sts_o.sweep_last  = sweep_q == ADDR_W'(CELL_TOTAL - 1);
  assign sts_o.search_done = !go;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      for (int i = 0; i < 4; i++) total_q[i] <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sts_o.sweep_last ? '0 : sweep_q + 1'b1;
      for (int i = 0; i < 4; i++) total_q[i] <= '0;
    end else if (cmd_i.upd && dim_ok) begin
      total_q[oc_q] <= tinc;
    end
  end

  // result register
  logic [OC_W-1:0]      oc_out_q;
  logic [BAND_W-1:0]    band_out_q;
  logic [OUT_CNT_W-1:0] cell_out_q, total_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_out) begin
      oc_out_q    <= '0;
      band_out_q  <= '0;
      cell_out_q  <= '0;
      total_out_q <= '0;
    end else if (cmd_i.upd) begin
      oc_out_q    <= oc_q;
      band_out_q  <= cnt_q;
      cell_out_q  <= dim_ok ? OUT_CNT_W'(inc) : '0;
      total_out_q <= dim_ok ? OUT_CNT_W'(tinc) : OUT_CNT_W'(tsel);
    end
  end

  assign outcome_o     = oc_out_q;
  assign band_o        = band_out_q;
  assign cell_count_o  = cell_out_q;
  assign total_count_o = total_out_q;

endmodule

FILE: hdl/banded_confusion_counter.sv
// Banded confusion counter: classifies a result, finds its margin band, counts it.
// Steps of a request: setup, step multiply, B + 1 band tests, counter read, write-back,
//   B the number of bands entered (at most the band count).
// Only one request is in work at a time, and a stalled response
//   holds the write-back. Clear request: sweeps (MAX_BANDS+1)*NUM_DIMS*4 entries, one a
//   cycle (272 at defaults), then returns an all-zero response. Reset runs the same sweep.
module banded_confusion_counter import bcc_pkg::*; #(
  parameter int NUM_DIMS    = 4,
  parameter int MAX_BANDS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcc_cfg_if.sink   cfg_req,
  bcc_in_if.sink    in_req,
  bcc_out_if.source out_rsp
);

  bcc_cmd_t cmd;
  bcc_sts_t sts;
  logic     cfg_we;

  // Configuration is always taken and lands at once; write only while no request is in work.
  assign cfg_req.ready = 1'b1;
  assign cfg_we        = cfg_req.valid;

  // Sequencer: owns the handshakes and steps the datapath through each request.
  bcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_mode_i   (in_req.mode),
    .in_ready_o  (in_req.ready),
    .out_valid_o (out_rsp.valid),
    .out_ready_i (out_rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: registers, band search, counter store and the response register.
  bcc_dp #(
    .NUM_DIMS    (NUM_DIMS),
    .MAX_BANDS   (MAX_BANDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_req.index),
    .cfg_data_i    (cfg_req.data),
    .dim_index_i   (in_req.dim_index),
    .expected_i    (in_req.expected),
    .actual_i      (in_req.actual),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .outcome_o     (out_rsp.outcome),
    .band_o        (out_rsp.band),
    .cell_count_o  (out_rsp.cell_count),
    .total_count_o (out_rsp.total_count)
  );

endmodule

FILE: tb/sv/bcc_tb_pkg.sv
// Request and response types plus the counter predictor used by the confusion counter bench.
package bcc_tb_pkg;
  import bcc_pkg::*;

  localparam int NUM_DIMS       = 4;
  localparam int MAX_BANDS      = 16;
  localparam int COUNT_WIDTH    = 32;
  localparam int CELLS          = (MAX_BANDS + 1) * NUM_DIMS * 4;
  localparam int SHOWN_FAILURES = 10;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] dim;
    logic [VAL_W-1:0] expected;
    logic [VAL_W-1:0] actual;
  } sample_t;

  typedef struct packed {
    outcome_e             outcome;
    logic [BAND_W-1:0]    band;
    logic [OUT_CNT_W-1:0] cell_count;
    logic [OUT_CNT_W-1:0] total_count;
  } tally_t;

  class confusion_predictor;
    logic [RATE_W-1:0]       band_rate;
    logic [NB_W-1:0]         num_bands;
    logic signed [VAL_W-1:0] middle [NUM_MIDDLES];
    longint unsigned         cell_cnt [CELLS];
    longint unsigned         total_cnt [4];
    tally_t                  expected_tallies [$];
    int                      mismatches;
    int                      strays;

    function new();
      band_rate = RATE_RESET;
      num_bands = NB_RESET;
      foreach (middle[i]) middle[i] = '0;
      clear_counts();
      mismatches = 0;
      strays     = 0;
    endfunction

    function void clear_counts();
      foreach (cell_cnt[i]) cell_cnt[i] = 0;
      foreach (total_cnt[i]) total_cnt[i] = 0;
    endfunction

    function longint unsigned bump(longint unsigned c);
      longint unsigned top;
      top = (~64'd0) >> (64 - COUNT_WIDTH);
      return (c >= top) ? top : c + 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BAND_RATE: band_rate = data[RATE_W-1:0];
        REG_NUM_BANDS: num_bands = data[NB_W-1:0];
        REG_MIDDLE_0, REG_MIDDLE_1, REG_MIDDLE_2, REG_MIDDLE_3:
          middle[int'(idx) - int'(REG_MIDDLE_0)] = data[VAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Classify one accepted sample, find its band, update the counters.
    function void note_request(sample_t s);
      longint      e, a, m, big_e, big_a, big_m, span, off;
      int unsigned lim, cnt, slot;
      outcome_e    oc;
      tally_t      t;
      t = '0;
      if (s.mode == MODE_CLEAR) begin
        clear_counts();
        expected_tallies.push_back(t);
        return;
      end
      e     = longint'($signed(s.expected));
      a     = longint'($signed(s.actual));
      m     = longint'(middle[s.dim]);
      big_e = e * 65536;
      big_a = a * 65536;
      big_m = m * 65536;
      lim   = (int'(num_bands) > MAX_BANDS) ? MAX_BANDS : int'(num_bands);
      cnt   = 0;
      if (e > m) begin
        span = e - m;
        while (cnt < lim) begin
          off = longint'(cnt + 1) * span * longint'(band_rate);
          if (!(big_a < big_e - off && big_a > 2 * big_m - big_e + off)) break;
          cnt++;
        end
        oc = (a >= m) ? OC_TN : OC_FP;
      end else begin
        span = m - e;
        while (cnt < lim) begin
          off = longint'(cnt + 1) * span * longint'(band_rate);
          if (!(big_a > big_e + off && big_a < 2 * big_m - big_e - off)) break;
          cnt++;
        end
        oc = (a <= m) ? OC_TP : OC_FN;
      end
      t.outcome = oc;
      t.band    = cnt[BAND_W-1:0];
      if (s.dim < NUM_DIMS) begin
        slot = (cnt * NUM_DIMS + s.dim) * 4 + oc;
        if (slot < CELLS) begin
          cell_cnt[slot] = bump(cell_cnt[slot]);
          t.cell_count   = cell_cnt[slot][OUT_CNT_W-1:0];
        end
        total_cnt[oc] = bump(total_cnt[oc]);
      end
      t.total_count = total_cnt[oc][OUT_CNT_W-1:0];
      expected_tallies.push_back(t);
    endfunction

    function void check_response(tally_t got);
      tally_t want;
      if (expected_tallies.size() == 0) begin
        strays++;
        if (strays + mismatches <= SHOWN_FAILURES)
          $display("unexpected response: oc %0d band %0d cell %0d total %0d",
                   got.outcome, got.band, got.cell_count, got.total_count);
        return;
      end
      want = expected_tallies.pop_front();
      if (got.outcome !== want.outcome || got.band !== want.band ||
          got.cell_count !== want.cell_count || got.total_count !== want.total_count) begin
        mismatches++;
        if (strays + mismatches <= SHOWN_FAILURES)
          $display({"response mismatch: want oc %0d band %0d cell %0d total %0d,",
                    " got oc %0d band %0d cell %0d total %0d"},
                   want.outcome, want.band, want.cell_count, want.total_count,
                   got.outcome, got.band, got.cell_count, got.total_count);
      end
    endfunction

    function int outstanding();
      return expected_tallies.size();
    endfunction

    function int failures();
      if (expected_tallies.size() != 0)
        $display("%0d responses never arrived", expected_tallies.size());
      return mismatches + strays + expected_tallies.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
// Self-checking bench for the banded confusion counter: directed corners, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;
  import bcc_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 104;
  localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES  = 40;    // longer than the deepest band search
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bcc_cfg_if cfg_req ();
  bcc_in_if  in_req ();
  bcc_out_if out_rsp ();

  banded_confusion_counter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_req (cfg_req),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  confusion_predictor tally_model = new();

  int gap_pct      = 0;     // chance of a sender gap before a request
  bit quiet        = 1'b0;  // no idling on either side
  bit rsp_hold_req = 1'b0;  // ask the receiver for one long hold-off

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Check every accepted response against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_rsp.valid && out_rsp.ready)
      tally_model.check_response(tally_t'({out_rsp.outcome, out_rsp.band,
                                           out_rsp.cell_count, out_rsp.total_count}));
  end

  // Receiver: random stall bursts in windows of varying density, plus one long hold.
  initial begin : rsp_side
    int hold_left;
    int window_left;
    int idle_pct;
    hold_left   = 0;
    window_left = 0;
    idle_pct    = 0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (window_left == 0) begin
        window_left = $urandom_range(50, 200);
        case ($urandom_range(0, 3))
          0, 1:    idle_pct = 0;
          2:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
      end
      window_left--;
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left    = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
        hold_left = $urandom_range(1, 15);
      end
      if (hold_left > 0) begin
        out_rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  function automatic int clamp_q15(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Offer one request, maybe after a gap, and hold it until the block takes it.
  task automatic send_sample(logic mode, logic [DIM_W-1:0] dim, int expected, int actual);
    sample_t s;
    s.mode     = mode;
    s.dim      = dim;
    s.expected = expected[VAL_W-1:0];
    s.actual   = actual[VAL_W-1:0];
    if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_req.valid     <= 1'b1;
    in_req.mode      <= s.mode;
    in_req.dim_index <= s.dim;
    in_req.expected  <= s.expected;
    in_req.actual    <= s.actual;
    do @(posedge clk_i); while (in_req.ready !== 1'b1);
    tally_model.note_request(s);
  endtask

  // Drop the request line and wait until every predicted response is back.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (tally_model.outstanding() != 0) @(posedge clk_i);
  endtask

  // Keep valid high across back-to-back writes; the caller drops it after the batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_req.valid <= 1'b1;
    cfg_req.index <= idx;
    cfg_req.data  <= data;
    do @(posedge clk_i); while (cfg_req.ready !== 1'b1);
    tally_model.write_reg(idx, data);
  endtask

  // Write every register; upper data bits carry noise the block must ignore.
  task automatic load_setting(int rate, int bands, int m0, int m1, int m2, int m3);
    int                    mids [NUM_MIDDLES];
    logic [CFG_DATA_W-1:0] noise;
    mids  = '{m0, m1, m2, m3};
    noise = $urandom();
    write_reg(REG_BAND_RATE, (noise << RATE_W) | (rate & ((1 << RATE_W) - 1)));
    noise = $urandom();
    write_reg(REG_NUM_BANDS, (noise << NB_W) | (bands & ((1 << NB_W) - 1)));
    for (int i = 0; i < NUM_MIDDLES; i++) begin
      noise = $urandom();
      write_reg(CFG_IDX_W'(REG_MIDDLE_0 + i), (noise << VAL_W) | (mids[i] & 16'hFFFF));
    end
    cfg_req.valid <= 1'b0;
  endtask

  // Mostly well-formed pairs around a midpoint, aimed at band edges; some noise and clears.
  task automatic send_random_sample();
    int     pick, dim, m, d, e, span, lim, k, jit;
    longint a, off;
    pick = $urandom_range(0, 99);
    dim  = $urandom_range(0, NUM_MIDDLES - 1);
    m    = tally_model.middle[dim];
    if (pick < 3) begin
      send_sample(MODE_CLEAR, DIM_W'($urandom()), $urandom(), $urandom());
    end else if (pick < 20) begin
      send_sample(MODE_ADD, DIM_W'(dim), $urandom(), $urandom());
    end else begin
      d    = (pick < 25) ? 0 : $urandom_range(0, (2 << $urandom_range(0, 15)) - 1);
      e    = clamp_q15($urandom_range(0, 1) ? longint'(m) + d : longint'(m) - d);
      span = (e > m) ? e - m : m - e;
      lim  = (int'(tally_model.num_bands) > MAX_BANDS) ? MAX_BANDS :
             int'(tally_model.num_bands);
      if (pick < 50) begin
        // land on or next to the edge of a band, either side of the window
        k   = $urandom_range(1, (lim == 0) ? 1 : lim);
        off = (longint'(k) * span * longint'(tally_model.band_rate)) >>> 16;
        jit = $urandom_range(0, 2) - 1;
        if (e > m)
          a = $urandom_range(0, 1) ? longint'(e) - off + jit : 2 * longint'(m) - e + off + jit;
        else
          a = $urandom_range(0, 1) ? longint'(e) + off + jit : 2 * longint'(m) - e - off + jit;
      end else if (pick < 55) begin
        a = m;
      end else begin
        a = longint'(m) + $urandom_range(0, 2 * span) - span;
      end
      send_sample(MODE_ADD, DIM_W'(dim), e, clamp_q15(a));
    end
  endtask

  initial begin : stimulus
    int rates [PHASES];
    int bands [PHASES];
    int gaps  [PHASES];
    int guard;
    rates = '{4096, 0, 65536, 1, 131071, 0, 8192, 20000};
    bands = '{16, 31, 1, 16, 16, 0, 8, 17};
    gaps  = '{0, 20, 50, 10, 30, 5, 40, 0};

    // hold every block input at a known value from time zero
    in_req.valid      <= 1'b0;
    in_req.mode       <= MODE_ADD;
    in_req.dim_index  <= '0;
    in_req.expected   <= '0;
    in_req.actual     <= '0;
    cfg_req.valid     <= 1'b0;
    cfg_req.index     <= REG_BAND_RATE;
    cfg_req.data      <= '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners under reset settings: unit rate, one band, midpoints at zero.
    gap_pct = 25;
    send_sample(MODE_ADD, 2'd0, 0, 0);            // expected on the midpoint
    send_sample(MODE_ADD, 2'd1, 32767, -32768);   // false positive, full swing
    send_sample(MODE_ADD, 2'd2, -32768, 32767);   // false negative, full swing
    send_sample(MODE_ADD, 2'd3, 32767, 32767);
    send_sample(MODE_ADD, 2'd0, -32768, -32768);
    send_sample(MODE_ADD, 2'd1, 100, 0);          // actual on the midpoint, upper side
    send_sample(MODE_ADD, 2'd2, -100, 1);
    send_sample(MODE_CLEAR, 2'd3, -1, -1);        // clear with every field bit set
    send_sample(MODE_ADD, 2'd0, 0, 0);            // counts restart from one
    drain();

    // Quarter-step bands: exact edges, mirrored side, extreme midpoints.
    write_reg(REG_UNMAPPED, $urandom());
    load_setting(16384, 16, -32768, 32767, 0, 1000);
    send_sample(MODE_ADD, 2'd3, 1400, 1300);      // exactly on the first edge: band 0
    send_sample(MODE_ADD, 2'd3, 1400, 1299);      // just inside: band 1
    send_sample(MODE_ADD, 2'd3, 1400, 1000);
    send_sample(MODE_ADD, 2'd3, 600, 1000);       // lower branch, mirrored bounds
    send_sample(MODE_ADD, 2'd3, 600, 701);
    send_sample(MODE_ADD, 2'd0, -32768, -32768);
    send_sample(MODE_ADD, 2'd0, 32767, 0);        // widest possible distance
    send_sample(MODE_ADD, 2'd1, -32768, 32767);
    send_sample(MODE_ADD, 2'd2, 32767, -32768);
    drain();

    // Zero band count: band stays 0.
    load_setting(16384, 0, 0, 0, 0, 0);
    send_sample(MODE_ADD, 2'd2, 1000, 0);
    drain();
    // Zero rate with an oversized count: capped at the maximum band.
    load_setting(0, 31, 0, 0, 0, 0);
    send_sample(MODE_ADD, 2'd2, 1000, 500);
    drain();
    // Rate above one: no band can be entered.
    load_setting(131071, 16, 0, 0, 0, 0);
    send_sample(MODE_ADD, 2'd2, 1000, 0);

    // Random phases, each under its own setting, reloaded only when idle.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 2)
        load_setting(rates[p], bands[p], 32767, -32768, 32767, -32768);
      else if (p == 5)
        load_setting($urandom_range(0, 131071), $urandom_range(0, 31),
                     $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                     $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
      else
        load_setting(rates[p], bands[p],
                     $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                     $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
      gap_pct = gaps[p];
      quiet   = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the output for a long stretch while requests keep coming
        if (p == 3 && n == 30) rsp_hold_req = 1'b1;
        send_random_sample();
      end
    end

    in_req.valid <= 1'b0;
    guard = 0;
    while (tally_model.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tally_model.failures() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/bcc_pkg.sv
hdl/bcc_if.sv
hdl/bcc_ctrl.sv
hdl/bcc_dp.sv
hdl/banded_confusion_counter.sv
tb/sv/bcc_tb_pkg.sv
tb/sv/tb.sv
